FILE: rtl/core/kiss_rng_pkg.sv
package kiss_rng_pkg;

	typedef enum logic [1:0] {
		MODE_DRAW = 2'd0,
		MODE_SEED = 2'd1,
		MODE_LOAD = 2'd2,
		MODE_READ = 2'd3
	} kiss_mode_t;

	localparam logic [2:0] IDX_LCG   = 3'd0;
	localparam logic [2:0] IDX_XOR   = 3'd1;
	localparam logic [2:0] IDX_LAG_L = 3'd2;
	localparam logic [2:0] IDX_LAG_H = 3'd3;
	localparam logic [2:0] IDX_CARRY = 3'd4;

	localparam logic [31:0] LCG_MULT    = 32'd69069;
	localparam logic [31:0] LCG_INC     = 32'd1;
	localparam logic [31:0] SEED_XOR    = 32'd102;
	localparam logic [31:0] SEED_LAG_L  = 32'd12;
	localparam logic [31:0] SEED_LAG_H  = 32'd34535;
	localparam int          XS_SHIFT_A  = 13;
	localparam int          XS_SHIFT_B  = 17;
	localparam int          XS_SHIFT_C  = 5;
	localparam int          CARRY_SHIFT = 30;

	typedef struct packed {
		logic [31:0] lcg;
		logic [31:0] xs;
		logic [31:0] lag_l;
		logic [31:0] lag_h;
		logic [31:0] carry;
	} kiss_state_t;

	// one step of all three generators
	function automatic kiss_state_t kiss_advance(input kiss_state_t s);
		kiss_state_t n;
		logic [31:0] y;
		logic [31:0] k;
		y = s.xs;
		y = y ^ (y << XS_SHIFT_A);
		y = y ^ (y >> XS_SHIFT_B);
		y = y ^ (y << XS_SHIFT_C);
		k = (s.lag_l >> 2) + (s.lag_h >> 3) + (s.carry >> 2);
		n.lcg   = s.lcg * LCG_MULT + LCG_INC;
		n.xs    = y;
		n.lag_l = s.lag_h;
		n.lag_h = s.lag_h + s.lag_h + s.lag_l + s.carry;
		n.carry = k >> CARRY_SHIFT;
		return n;
	endfunction

endpackage

FILE: rtl/core/kiss_random_generator_top.sv
// a word goes into the input register, its result word into the output register
// throughput: one word per cycle unless the output stalls; draws may go back to back
// the state update and the result (one 32x32 multiply, xorshift, adds) sit
// between the input register and the output register
// reset: arst_n low clears all five state words and both valid flags at once
module kiss_random_generator_top
	import kiss_rng_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [31:0] data_word,
	input  logic [2:0]  word_index,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_value
);

	// input register
	logic        valid_s1;
	kiss_mode_t  mode_s1;
	logic [31:0] data_s1;
	logic [2:0]  idx_s1;

	// generator state
	kiss_state_t st_q;
	kiss_state_t st_next;
	kiss_state_t adv;
	kiss_state_t seeded;

	// output register
	logic        out_valid_q;
	logic [31:0] out_value_q;

	logic        has_result;
	logic        out_free;
	logic        s1_fire;
	logic        in_fire;
	logic [31:0] result;
	logic [31:0] read_word;

	// draw and read words give one result, seed and load none
	assign has_result = valid_s1 && (mode_s1 == MODE_DRAW || mode_s1 == MODE_READ);
	assign out_free   = !out_valid_q || !out_stall;
	// the stage holds only when its result cannot go to the output register
	assign in_stall   = has_result && !out_free;
	assign s1_fire    = valid_s1 && !in_stall;
	assign in_fire    = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			mode_s1 <= kiss_mode_t'(mode);
			data_s1 <= data_word;
			idx_s1  <= word_index;
		end
	end

	// seed takes the lcg word from data, the rest from fixed words, but keeps the carry
	always_comb begin
		seeded       = st_q;
		seeded.lcg   = data_s1;
		seeded.xs    = SEED_XOR;
		seeded.lag_l = SEED_LAG_L;
		seeded.lag_h = SEED_LAG_H;
		adv = kiss_advance((mode_s1 == MODE_SEED) ? seeded : st_q);
	end

	always_comb begin
		case (idx_s1)
			IDX_LCG:   read_word = st_q.lcg;
			IDX_XOR:   read_word = st_q.xs;
			IDX_LAG_L: read_word = st_q.lag_l;
			IDX_LAG_H: read_word = st_q.lag_h;
			IDX_CARRY: read_word = st_q.carry;
			default:   read_word = 32'd0;
		endcase
	end

	always_comb begin
		st_next = st_q;
		result  = read_word;
		unique case (mode_s1)
			MODE_DRAW: begin
				st_next = adv;
				result  = adv.lcg + adv.xs + adv.lag_l;
			end
			MODE_SEED: begin
				st_next = adv;
			end
			MODE_LOAD: begin
				case (idx_s1)
					IDX_LCG:   st_next.lcg   = data_s1;
					IDX_XOR:   st_next.xs    = data_s1;
					IDX_LAG_L: st_next.lag_l = data_s1;
					IDX_LAG_H: st_next.lag_h = data_s1;
					IDX_CARRY: st_next.carry = data_s1;
					default:   st_next       = st_q;
				endcase
			end
			MODE_READ: begin
				result = read_word;
			end
			default: begin
				st_next = st_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (s1_fire) begin
			st_q <= st_next;
		end
	end

	// result register, refilled in the same cycle it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (has_result && out_free) begin
			out_value_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;

endmodule

FILE: rtl/core/kiss_rng_checker.sv
module kiss_rng_checker
	import kiss_rng_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] out_value
);

	// a stalled result word stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_value))
		else $error("stalled result word changed");

	// input is held back only by a full, stalled output register
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back pressure");

	// a fresh result word needs a word accepted earlier through the input register
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result word without accepted input word");

	// nothing comes out while in reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

endmodule

bind kiss_random_generator_top kiss_rng_checker u_kiss_rng_checker (.*);
